>>> rtl/best_fit_region_allocator_macros.svh
// Assertion macros for the best-fit region allocator.
// Depends on nothing; included by the top level.
`ifndef BEST_FIT_REGION_ALLOCATOR_MACROS_SVH
`define BEST_FIT_REGION_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BFRA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BFRA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/bfra_pkg.sv
// Shared constants and types of the best-fit region allocator.
// Depends on nothing.
package bfra_pkg;
	localparam int MaxSegments = 64;
	localparam int NumHandles  = 256;
	localparam int AddrBits    = 32;
	localparam int SegIdxBits  = $clog2(MaxSegments);
	localparam int SegCntBits  = $clog2(MaxSegments + 1);
	localparam int HndBits     = $clog2(NumHandles);

	typedef logic [AddrBits-1:0]   addr_t;
	typedef logic [SegIdxBits-1:0] seg_idx_t;
	typedef logic [SegCntBits-1:0] seg_cnt_t;
	typedef logic [HndBits-1:0]    hnd_t;

	typedef enum logic [2:0] {
		ST_ALLOC    = 3'd0,
		ST_NOFIT    = 3'd1,
		ST_FREED    = 3'd2,
		ST_NOTALLOC = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_t;

	localparam addr_t PoolReset = addr_t'(65536);
endpackage

>>> rtl/bfra_if.sv
// Valid/ready channel interfaces of the allocator.
// Depends on nothing.
interface bfra_req_if;
	logic           valid;
	logic           ready;
	logic           operation;
	logic [7:0]     handle;
	logic [31:0]    length;
	modport source (output valid, operation, handle, length, input ready);
	modport sink   (input valid, operation, handle, length, output ready);
endinterface

interface bfra_rsp_if;
	logic           valid;
	logic           ready;
	logic [2:0]     status;
	logic [31:0]    address;
	modport source (output valid, status, address, input ready);
	modport sink   (input valid, status, address, output ready);
endinterface

>>> rtl/bfra_seg_table.sv
// Segment table: start, length and free flag per entry, with one
// registered read port and one write port. Depends on bfra_pkg.
module bfra_seg_table (
	input  logic                clk,
	input  logic                we,
	input  bfra_pkg::seg_idx_t  waddr,
	input  bfra_pkg::addr_t     wstart,
	input  bfra_pkg::addr_t     wlen,
	input  logic                wfree,
	input  bfra_pkg::seg_idx_t  raddr,
	output bfra_pkg::addr_t     rstart,
	output bfra_pkg::addr_t     rlen,
	output logic                rfree
);
	bfra_pkg::addr_t mem_start [bfra_pkg::MaxSegments];
	bfra_pkg::addr_t mem_len   [bfra_pkg::MaxSegments];
	logic            mem_free  [bfra_pkg::MaxSegments];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[waddr] <= wstart;
			mem_len[waddr]   <= wlen;
			mem_free[waddr]  <= wfree;
		end
		rstart <= mem_start[raddr];
		rlen   <= mem_len[raddr];
		rfree  <= mem_free[raddr];
	end
endmodule

>>> rtl/best_fit_region_allocator.sv
// Best-fit region allocator. An allocate scans all entries for the smallest free one
// that fits; a split shifts later entries up. A free finds its handle's entry, merges
// it with free neighbours and removes merged entries by shifting later ones down.
// One item at a time: the next beat waits until the response beat is taken and
// out_valid_q has cleared. Asynchronous active-low reset gives one free segment
// of 65536 units. Depends on bfra_pkg, bfra_if, bfra_seg_table, macros.
`include "best_fit_region_allocator_macros.svh"
module best_fit_region_allocator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	bfra_req_if.sink             req,
	bfra_rsp_if.source           rsp
);
	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_FIT, S_SHR_RD, S_SHR_WR, S_SPLIT,
		S_FIND_RD, S_FIND_CMP, S_NXT_RD, S_NXT_CHK, S_PRV_RD, S_PRV_CHK,
		S_SHL_RD, S_SHL_WR, S_DONE
	} state_t;

	state_t               state_q;
	bfra_pkg::seg_cnt_t   count_q;
	bfra_pkg::seg_cnt_t   idx_q;
	bfra_pkg::seg_cnt_t   best_q;
	logic                 found_q;
	bfra_pkg::addr_t      best_len_q;
	bfra_pkg::addr_t      best_start_q;
	bfra_pkg::addr_t      cur_len_q;
	bfra_pkg::seg_cnt_t   del_q;
	logic                 op_q;
	bfra_pkg::hnd_t       hnd_q;
	bfra_pkg::addr_t      len_q;
	bfra_pkg::addr_t      faddr_q;
	logic                 prv_pending_q;
	logic                 out_valid_q;
	bfra_pkg::status_t    out_status_q;
	bfra_pkg::addr_t      out_addr_q;
	logic                 init_q;
	bfra_pkg::addr_t      pool_q;
	bfra_pkg::addr_t      hmem [bfra_pkg::NumHandles];
	logic [bfra_pkg::NumHandles-1:0] live_q;
	bfra_pkg::addr_t      hrd_q;

	logic                 we;
	bfra_pkg::seg_idx_t   waddr, raddr;
	bfra_pkg::addr_t      wstart, wlen, rstart, rlen;
	logic                 wfree, rfree;

	bfra_seg_table u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wlen(wlen),
		.wfree(wfree), .raddr(raddr), .rstart(rstart), .rlen(rlen), .rfree(rfree)
	);

	// Shared adder and comparators.
	bfra_pkg::addr_t cmp_a, cmp_b;
	logic            ge, lt;
	logic [bfra_pkg::AddrBits:0] sum;
	always_comb begin
		cmp_a = rlen;
		cmp_b = len_q;
		ge    = cmp_a >= cmp_b;
		lt    = cmp_a < best_len_q;
		sum   = {1'b0, cur_len_q} + {1'b0, rlen};
	end

	assign req.ready = (state_q == S_IDLE) && !out_valid_q && !init_q;
	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.address = out_addr_q;

	// Handle address memory.
	always_ff @(posedge clk) begin
		if (state_q == S_FIT && found_q && !(best_len_q != len_q &&
			count_q == bfra_pkg::seg_cnt_t'(bfra_pkg::MaxSegments)))
			hmem[hnd_q] <= best_start_q;
		hrd_q <= hmem[req.handle[bfra_pkg::HndBits-1:0]];
	end

	// Table port control.
	always_comb begin
		we = 1'b0; waddr = idx_q[bfra_pkg::SegIdxBits-1:0];
		wstart = rstart; wlen = rlen; wfree = rfree;
		raddr = idx_q[bfra_pkg::SegIdxBits-1:0];
		unique case (state_q)
			S_SHR_WR: waddr = bfra_pkg::seg_idx_t'(idx_q + 1'b1);
			S_SPLIT: begin
				we = 1'b1; waddr = bfra_pkg::seg_idx_t'(best_q + 1'b1);
				wstart = best_start_q + len_q; wlen = best_len_q - len_q; wfree = 1'b1;
			end
			S_SHL_RD: raddr = bfra_pkg::seg_idx_t'(idx_q + 1'b1);
			default: ;
		endcase
		if (state_q == S_SHR_WR || state_q == S_SHL_WR) we = 1'b1;
		if (init_q) begin
			we = 1'b1; waddr = '0; wstart = '0; wlen = pool_q; wfree = 1'b1;
		end
		// The allocated entry is written at once; a shift only moves later entries.
		if (state_q == S_FIT && found_q) begin
			we = 1'b1; waddr = bfra_pkg::seg_idx_t'(best_q); wstart = best_start_q;
			wlen = len_q; wfree = 1'b0;
			if (best_len_q != len_q &&
				count_q == bfra_pkg::seg_cnt_t'(bfra_pkg::MaxSegments)) we = 1'b0;
		end
		if (state_q == S_NXT_CHK || state_q == S_PRV_CHK) begin
			we = 1'b1; waddr = bfra_pkg::seg_idx_t'(del_q);
			wstart = best_start_q; wlen = cur_len_q; wfree = 1'b1;
			if (state_q == S_NXT_CHK && idx_q < count_q && rfree)
				wlen = sum[bfra_pkg::AddrBits-1:0];
			if (state_q == S_PRV_CHK) begin
				if (rfree) begin
					waddr = bfra_pkg::seg_idx_t'(idx_q); wstart = rstart;
					wlen = sum[bfra_pkg::AddrBits-1:0];
				end
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; count_q <= '0; init_q <= 1'b1; pool_q <= bfra_pkg::PoolReset;
			live_q <= '0; out_valid_q <= 1'b0; found_q <= 1'b0; idx_q <= '0;
			prv_pending_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			if (init_q) begin
				init_q <= 1'b0;
				count_q <= (pool_q != '0) ? bfra_pkg::seg_cnt_t'(1) : '0;
			end
			if (cfg_we) begin
				pool_q <= bfra_pkg::addr_t'(cfg_wdata); init_q <= 1'b1; live_q <= '0;
			end
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					op_q <= req.operation; hnd_q <= req.handle[bfra_pkg::HndBits-1:0];
					len_q <= req.length; idx_q <= '0; found_q <= 1'b0;
					state_q <= (req.operation == bfra_pkg::OP_ALLOC) ? S_SCAN_RD : S_FIND_RD;
				end
				S_SCAN_RD: state_q <= (idx_q < count_q) ? S_SCAN_CMP : S_FIT;
				S_SCAN_CMP: begin
					if (rfree && ge && len_q != '0 && (!found_q || lt)) begin
						found_q <= 1'b1; best_q <= idx_q; best_len_q <= rlen;
						best_start_q <= rstart;
					end
					idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
				end
				S_FIT: begin
					out_addr_q <= '0;
					if (!found_q) begin
						out_status_q <= bfra_pkg::ST_NOFIT; state_q <= S_DONE;
					end else if (best_len_q != len_q &&
						count_q == bfra_pkg::seg_cnt_t'(bfra_pkg::MaxSegments)) begin
						out_status_q <= bfra_pkg::ST_FULL; state_q <= S_DONE;
					end else begin
						out_status_q <= bfra_pkg::ST_ALLOC; out_addr_q <= best_start_q;
						live_q[hnd_q] <= 1'b1;
						if (best_len_q == len_q) state_q <= S_DONE;
						else if (best_q + 1'b1 == count_q) state_q <= S_SPLIT;
						else begin
							idx_q <= count_q - 1'b1; state_q <= S_SHR_RD;
						end
					end
				end
				S_SHR_RD: state_q <= S_SHR_WR;
				S_SHR_WR: begin
					if (idx_q == best_q + 1'b1) state_q <= S_SPLIT;
					else begin
						idx_q <= idx_q - 1'b1; state_q <= S_SHR_RD;
					end
				end
				S_SPLIT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_FIND_RD: begin
					if (op_q == bfra_pkg::OP_FREE && idx_q == '0) faddr_q <= hrd_q;
					state_q <= (idx_q < count_q) ? S_FIND_CMP : S_DONE;
					if (!(idx_q < count_q)) begin
						out_status_q <= live_q[hnd_q] ? bfra_pkg::ST_FREED
							: bfra_pkg::ST_NOTALLOC;
						out_addr_q <= '0; live_q[hnd_q] <= 1'b0;
					end
				end
				S_FIND_CMP: begin
					if (!live_q[hnd_q]) begin
						out_status_q <= bfra_pkg::ST_NOTALLOC; out_addr_q <= '0;
						state_q <= S_DONE;
					end else if (rstart == faddr_q && !rfree) begin
						live_q[hnd_q] <= 1'b0; out_status_q <= bfra_pkg::ST_FREED;
						out_addr_q <= '0; del_q <= idx_q; best_start_q <= rstart;
						cur_len_q <= rlen; idx_q <= idx_q + 1'b1; state_q <= S_NXT_RD;
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= S_FIND_RD;
					end
				end
				S_NXT_RD: state_q <= S_NXT_CHK;
				// Merge a free next entry and remove it by shifting down, else try the previous one.
				S_NXT_CHK: begin
					if (idx_q < count_q && rfree) begin
						cur_len_q <= sum[bfra_pkg::AddrBits-1:0];
						prv_pending_q <= 1'b1; state_q <= S_SHL_RD;
					end else if (del_q != '0) begin
						idx_q <= del_q - 1'b1; state_q <= S_PRV_RD;
					end else state_q <= S_DONE;
				end
				S_PRV_RD: state_q <= S_PRV_CHK;
				S_PRV_CHK: begin
					prv_pending_q <= 1'b0;
					if (rfree) begin
						idx_q <= del_q; state_q <= S_SHL_RD;
					end else state_q <= S_DONE;
				end
				// Shift entries above idx_q down by one; the last step drops the count.
				S_SHL_RD: begin
					state_q <= S_SHL_WR;
					if (idx_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1; prv_pending_q <= 1'b0;
						if (prv_pending_q && del_q != '0) begin
							idx_q <= del_q - 1'b1; state_q <= S_PRV_RD;
						end else state_q <= S_DONE;
					end
				end
				S_SHL_WR: begin
					idx_q <= idx_q + 1'b1; state_q <= S_SHL_RD;
				end
				S_DONE: begin
					out_valid_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BFRA_ASSERT_IMP(a_cnt_max, 1'b1, count_q <= bfra_pkg::seg_cnt_t'(bfra_pkg::MaxSegments))
	`BFRA_ASSERT_IMP(a_busy_no_ready, state_q != S_IDLE, !req.ready)
	`BFRA_ASSERT_NXT(a_done_valid, state_q == S_DONE, rsp.valid)
endmodule
